### design/spimb_pkg.sv
// Shared types and constants for the SPI master byte port.
// Holds request and register codes, clock divider lengths and the state/result structs.
// No dependencies.
package spimb_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned BC_W      = 4;
  localparam int unsigned PC_W      = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_IDLE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLR_INT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR_COLL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_A2I    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE    = 3'd4;

  localparam logic [1:0] RATE_DIV4  = 2'd0;
  localparam logic [1:0] RATE_DIV16 = 2'd1;

  localparam logic [PC_W:0] HALF_DIV4  = 7'd2;
  localparam logic [PC_W:0] HALF_DIV16 = 7'd8;
  localparam logic [PC_W:0] HALF_DIV64 = 7'd32;

  localparam logic [BC_W-1:0] LAST_HALF = BC_W'(2 * BYTE_BITS - 1);

  typedef struct packed {
    logic       enable;
    logic [1:0] rate;
    logic       idle_high;
    logic       tx_a2i;
    logic       sample_end;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic done;
    logic coll;
    logic busy;
  } flags_t;

  typedef struct packed {
    logic                 sck_level;
    logic                 mosi_bit;
    logic [BYTE_BITS-1:0] read_byte;
    flags_t               flags;
  } result_t;

endpackage

### design/spimb_in_if.sv
// Input channel of the SPI master byte port: valid/ready plus one bus-access item.
// Depends on spimb_pkg.
interface spimb_in_if import spimb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [BYTE_BITS-1:0] write_byte;
  logic                 miso_bit;

  modport source (output valid, req_type, write_byte, miso_bit, input ready);
  modport sink   (input valid, req_type, write_byte, miso_bit, output ready);
endinterface

### design/spimb_out_if.sv
// Output channel of the SPI master byte port: valid/ready plus one result item.
// Depends on spimb_pkg.
interface spimb_out_if import spimb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 sck_level;
  logic                 mosi_bit;
  logic [BYTE_BITS-1:0] read_byte;
  logic                 buffer_full;
  logic                 done_flag;
  logic                 collision;
  logic                 busy_res;

  modport source (output valid, sck_level, mosi_bit, read_byte, buffer_full, done_flag,
                  collision, busy_res, input ready);
  modport sink   (input valid, sck_level, mosi_bit, read_byte, buffer_full, done_flag,
                  collision, busy_res, output ready);
endinterface

### design/spimb_core.sv
// Exchange engine: shift register, bit and prescale counters, receive buffer and flags.
// Advances one system tick per accepted item; result reflects the state after the tick.
// Depends on spimb_pkg.
module spimb_core import spimb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  cfg_t                 cfg_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [BYTE_BITS-1:0] write_byte_i,
  input  logic                 miso_bit_i,
  output result_t              res_o
);

  logic [BYTE_BITS-1:0] shift_q, shift_d;
  logic [BC_W-1:0]      bc_q, bc_d;
  logic [PC_W-1:0]      pc_q, pc_d;
  logic [BYTE_BITS-1:0] rb_q, rb_d;
  logic                 latch_q, latch_d;
  flags_t               flags_q, flags_d;

  logic                 started;
  logic                 smp;
  logic                 phase;
  logic [PC_W:0]        half;
  logic [PC_W:0]        pc_inc;

  always_comb begin
    unique case (cfg_i.rate)
      RATE_DIV4:  half = HALF_DIV4;
      RATE_DIV16: half = HALF_DIV16;
      default:    half = HALF_DIV64;
    endcase
  end

  always_comb begin
    shift_d = shift_q;
    bc_d    = bc_q;
    pc_d    = pc_q;
    rb_d    = rb_q;
    latch_d = latch_q;
    flags_d = flags_q;
    started = 1'b0;
    smp     = 1'b0;
    pc_inc  = 7'd0;

    if (!cfg_i.enable) begin
      flags_d.busy = 1'b0;
      bc_d         = '0;
      pc_d         = '0;
    end

    unique case (req_type_i)
      REQ_WRITE: begin
        if (flags_d.busy) begin
          flags_d.coll = 1'b1;
        end else if (cfg_i.enable) begin
          shift_d      = write_byte_i;
          bc_d         = '0;
          pc_d         = '0;
          flags_d.busy = 1'b1;
          started      = 1'b1;
        end
      end
      REQ_READ:     flags_d.full = 1'b0;
      REQ_CLR_INT:  flags_d.done = 1'b0;
      REQ_CLR_COLL: flags_d.coll = 1'b0;
      default: ;
    endcase

    if (flags_d.busy && !started) begin
      pc_inc = {1'b0, pc_d} + 7'd1;
      if (pc_inc >= half) begin
        pc_d = '0;
        if (!bc_d[0]) begin
          if (!cfg_i.sample_end) latch_d = miso_bit_i;
          bc_d = bc_d + 4'd1;
        end else begin
          smp     = cfg_i.sample_end ? miso_bit_i : latch_d;
          shift_d = {shift_d[BYTE_BITS-2:0], smp};
          if (bc_d >= LAST_HALF) begin
            rb_d         = shift_d;
            flags_d.full = 1'b1;
            flags_d.done = 1'b1;
            flags_d.busy = 1'b0;
            bc_d         = '0;
          end else begin
            bc_d = bc_d + 4'd1;
          end
        end
      end else begin
        pc_d = pc_inc[PC_W-1:0];
      end
    end
  end

  assign phase = flags_d.busy ? (bc_d[0] == cfg_i.tx_a2i) : 1'b0;

  always_comb begin
    res_o.sck_level = phase ^ cfg_i.idle_high;
    res_o.mosi_bit  = flags_d.busy ? shift_d[BYTE_BITS-1] : 1'b0;
    res_o.read_byte = rb_d;
    res_o.flags     = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bc_q    <= '0;
      pc_q    <= '0;
      rb_q    <= '0;
      latch_q <= 1'b0;
      flags_q <= '0;
    end else if (adv_i) begin
      shift_q <= shift_d;
      bc_q    <= bc_d;
      pc_q    <= pc_d;
      rb_q    <= rb_d;
      latch_q <= latch_d;
      flags_q <= flags_d;
    end
  end

endmodule

### design/spi_master_byte_port_core.sv
// SPI master byte port: configuration registers, exchange engine and result register.
// A result is registered and appears in the cycle after its item is accepted; one item
// per cycle while results are taken, the output register letting a new item in as one is taken.
// Reset (rst_ni, asynchronous, active low) clears configuration, flags, counters and
// the result register; the clock pin idles low and no exchange runs.
// Depends on spimb_pkg, spimb_in_if, spimb_out_if and spimb_core.
module spi_master_byte_port_core import spimb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  spimb_in_if.sink             in_i,
  spimb_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:    cfg_q.enable     <= cfg_data_i[0];
        CFG_RATE:      cfg_q.rate       <= cfg_data_i;
        CFG_IDLE_HIGH: cfg_q.idle_high  <= cfg_data_i[0];
        CFG_TX_A2I:    cfg_q.tx_a2i     <= cfg_data_i[0];
        CFG_SAMPLE:    cfg_q.sample_end <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  spimb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (accept),
    .cfg_i        (cfg_q),
    .req_type_i   (in_i.req_type),
    .write_byte_i (in_i.write_byte),
    .miso_bit_i   (in_i.miso_bit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sck_level   = res_q.sck_level;
  assign out_o.mosi_bit    = res_q.mosi_bit;
  assign out_o.read_byte   = res_q.read_byte;
  assign out_o.buffer_full = res_q.flags.full;
  assign out_o.done_flag   = res_q.flags.done;
  assign out_o.collision   = res_q.flags.coll;
  assign out_o.busy_res    = res_q.flags.busy;

endmodule
